@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of clk outside reset.
`define GSAF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must never be seen at a rising edge of clk outside reset.
`define GSAF_NEVER(label, cond, msg) \
	`GSAF_ASSERT(label, !(cond), msg)

`endif

@@ rtl/core/gsaf_pkg.sv @@
// ----------------------------------------------------------------------------
// gsaf_pkg
// Types, codes and constants shared by the gas sensor adaptive filter.
// ----------------------------------------------------------------------------
package gsaf_pkg;

	localparam int unsigned DEF_SAMPLES_PER_BLOCK = 8;
	localparam int unsigned DEF_ZERO_HISTORY      = 8;

	// Divide by 100 as a multiply by the rounded-up reciprocal 2^37/100 and a
	// shift by 37, exact for every 32-bit dividend.
	localparam int unsigned DIV_W     = 32;
	localparam logic [31:0] DIV_MAGIC = 32'h51EB851F;
	localparam int unsigned DIV_SHIFT = 37;

	localparam logic [7:0]  QUIET_LIMIT = 8'd10;
	localparam logic [7:0]  RUN_LIMIT   = 8'd5;
	localparam logic [7:0]  READY_LIMIT = 8'd10;
	localparam logic [15:0] CO2_BASE    = 16'd400;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_WEIGHT    = 3'd0,
		REG_GAIN_PERCENT     = 3'd1,
		REG_PREHEAT_LENGTH   = 3'd2,
		REG_ZERO_RESET_COUNT = 3'd3,
		REG_INITIAL_ZERO     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_LOADING  = 2'd0,
		MODE_PREHEAT  = 2'd1,
		MODE_NORMAL   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MUL1,
		S_DIV1,
		S_MUL2,
		S_DIV2,
		S_CO2,
		S_GRADE,
		S_SYNC_WR,
		S_SYNC_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        action;
		logic [15:0] sample;
	} item_t;

	typedef struct packed {
		logic [15:0] raw_reading;
		logic [15:0] co2_value;
		logic [6:0]  air_level;
		logic [1:0]  mode;
		logic [15:0] zero_level;
		logic        is_sync;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic prep;
		logic div_go;
		logic second;
		logic co2;
		logic grade;
		logic sync_wr;
		logic scan;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic block_end;
		logic div_done;
		logic scan_last;
		logic out_free;
	} stat_t;

	// Air quality level from a co2 value. The divisions by 30, 40 and 160 are
	// reciprocal multiplies that are exact over their limited input ranges.
	function automatic logic [6:0] level_of(input logic [15:0] v);
		logic [15:0] d;
		logic [31:0] p;
		logic [6:0]  r;
		d = '0;
		p = '0;
		if (v < 16'd400) begin
			r = 7'd100;
		end else if (v < 16'd1000) begin
			d = v - 16'd400;
			p = 32'(d) * 32'd2185;
			r = 7'd100 - 7'(p >> 16);
		end else if (v < 16'd1800) begin
			d = v - 16'd1000;
			p = 32'(d) * 32'd1639;
			r = 7'd80 - 7'(p >> 16);
		end else if (v < 16'd5000) begin
			d = v - 16'd1800;
			p = 32'(d) * 32'd19662;
			r = 7'd60 - 7'(p >> 20);
		end else begin
			r = 7'd0;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/gsaf_div.sv @@
// ----------------------------------------------------------------------------
// gsaf_div
// Divide by the constant 100: the dividend is registered, then multiplied by
// the reciprocal and shifted in the following cycle.
// ----------------------------------------------------------------------------
module gsaf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gsaf_pkg::DIV_W-1:0]  dividend,
	output logic [gsaf_pkg::DIV_W-1:0]  quotient,
	output logic                        done
);
	import gsaf_pkg::*;

	logic [DIV_W-1:0]   d_q;
	logic [DIV_W-1:0]   q_q;
	logic               busy_q;
	logic               done_q;
	logic [2*DIV_W-1:0] prod;

	always_comb begin
		prod = (2*DIV_W)'(d_q) * (2*DIV_W)'(DIV_MAGIC);
	end

	// The quotient holds until the next division finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q    <= '0;
			q_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			d_q    <= dividend;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			q_q    <= DIV_W'(prod >> DIV_SHIFT);
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

@@ rtl/core/gsaf_ctrl.sv @@
// ----------------------------------------------------------------------------
// gsaf_ctrl
// Sequencer for reading processing, sync handling and result hand-off.
// ----------------------------------------------------------------------------
module gsaf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_action,
	input  gsaf_pkg::stat_t stat,
	output gsaf_pkg::cmd_t  cmd,
	output logic            item_stall
);
	import gsaf_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_action) begin
						state_n = S_SYNC_WR;
					end else if (stat.block_end) begin
						state_n = S_PREP;
					end
				end
			end
			S_PREP:      state_n = S_MUL1;
			S_MUL1:      state_n = S_DIV1;
			S_DIV1:      if (stat.div_done) state_n = S_MUL2;
			S_MUL2:      state_n = S_DIV2;
			S_DIV2:      if (stat.div_done) state_n = S_CO2;
			S_CO2:       state_n = S_GRADE;
			S_GRADE:     state_n = S_DONE;
			S_SYNC_WR:   state_n = S_SYNC_SCAN;
			S_SYNC_SCAN: if (stat.scan_last) state_n = S_DONE;
			S_DONE:      if (stat.out_free) state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == S_IDLE) && item_valid;
		cmd.prep     = (state_q == S_PREP);
		cmd.div_go   = (state_q == S_MUL1) || (state_q == S_MUL2);
		cmd.second   = (state_q == S_MUL2);
		cmd.co2      = (state_q == S_CO2);
		cmd.grade    = (state_q == S_GRADE);
		cmd.sync_wr  = (state_q == S_SYNC_WR);
		cmd.scan     = (state_q == S_SYNC_SCAN);
		cmd.load_out = (state_q == S_DONE) && stat.out_free;
		item_stall   = (state_q != S_IDLE);
	end

endmodule

@@ rtl/core/gsaf_dp.sv @@
// ----------------------------------------------------------------------------
// gsaf_dp
// Datapath: block trimming, filter state, zero tracking and result register.
// ----------------------------------------------------------------------------
module gsaf_dp #(
	parameter int unsigned SAMPLES_PER_BLOCK = gsaf_pkg::DEF_SAMPLES_PER_BLOCK,
	parameter int unsigned ZERO_HISTORY      = gsaf_pkg::DEF_ZERO_HISTORY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gsaf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gsaf_pkg::CFG_W-1:0]        cfg_data,
	input  gsaf_pkg::item_t                   item,
	input  gsaf_pkg::cmd_t                    cmd,
	input  logic                              result_stall,
	output gsaf_pkg::stat_t                   stat,
	output gsaf_pkg::result_t                 result,
	output logic                              result_valid
);
	import gsaf_pkg::*;

	localparam int unsigned CW = $clog2(SAMPLES_PER_BLOCK);
	localparam int unsigned HW = (ZERO_HISTORY > 1) ? $clog2(ZERO_HISTORY) : 1;

	// Configuration registers.
	logic [6:0]  fw_q;
	logic [15:0] gain_q;
	logic [7:0]  plen_q;
	logic [7:0]  zrc_q;
	logic [15:0] izero_q;

	// Block accumulation.
	logic [CW-1:0] cnt_q;
	logic [15:0]   sum_q, low_q, high_q;

	// Filter and zero state.
	logic [7:0]  pre_q, stable_q, ready_q, bz_q, rise_q, fall_q, boost_q, hidx_q;
	logic [15:0] filt_q, rlast_q, zero_q, pmin_q, m_q;
	mode_t       mode_q;
	logic [HW-1:0] wptr_q, scan_q;
	logic [15:0] hist_q [ZERO_HISTORY];

	// Per-reading work registers.
	logic [15:0] raw_q, adv_q, co2_q;
	logic [6:0]  w_q, lvl_q;
	logic        sync_q;
	result_t     out_q;
	logic        out_valid_q;

	// Divider interface.
	logic [DIV_W-1:0] dividend, quotient;
	logic             div_done;
	logic [22:0]      pa, pb;
	logic [31:0]      prod1;

	logic [15:0] sum_n, low_n, high_n, raw_n;
	logic        block_end;

	logic [7:0]  p_stable, p_ready, p_rise, p_fall, p_boost, p_bz, w_raw;
	logic [15:0] p_pmin, p_zero, p_adv;
	mode_t       p_mode;
	logic [6:0]  p_w;

	logic [15:0] hn, m_nx;
	logic        scan_last;

	gsaf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (dividend),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		prod1    = adv_q * gain_q;
		pa       = quotient[15:0] * w_q;
		pb       = filt_q * (7'd100 - w_q);
		dividend = cmd.second ? DIV_W'({1'b0, pa} + {1'b0, pb}) : prod1;
	end

	always_comb begin
		sum_n     = sum_q + item.sample;
		low_n     = (item.sample < low_q) ? item.sample : low_q;
		high_n    = (item.sample > high_q) ? item.sample : high_q;
		raw_n     = sum_n - low_n - high_n;
		block_end = (cnt_q == CW'(SAMPLES_PER_BLOCK - 1));
	end

	// Reading bookkeeping, all taken from the state before this reading.
	always_comb begin
		p_stable = stable_q;
		p_ready  = ready_q;
		p_mode   = mode_q;
		p_pmin   = pmin_q;
		w_raw    = {1'b0, fw_q};
		if (pre_q == 8'd0) begin
			w_raw = {1'b0, fw_q} + boost_q;
			if (stable_q != 8'd0) begin
				p_stable = stable_q - 8'd1;
				if (boost_q != 8'd0) begin
					p_ready = 8'd0;
				end else begin
					p_ready = ready_q + 8'd1;
					if (p_ready >= READY_LIMIT && p_stable > 8'd10) begin
						p_stable = p_stable - 8'd10;
						p_ready  = 8'd0;
					end
				end
			end else begin
				p_mode = MODE_NORMAL;
				if (pmin_q > raw_q && raw_q >= zero_q) p_pmin = raw_q;
			end
		end else if (pre_q < QUIET_LIMIT) begin
			p_stable = plen_q;
			p_ready  = 8'd0;
		end else begin
			p_mode = MODE_PREHEAT;
		end
		p_w   = (w_raw > 8'd100) ? 7'd100 : w_raw[6:0];
		p_adv = (raw_q > zero_q) ? raw_q - zero_q : 16'd0;

		// Rise and fall runs boost the filter weight.
		p_rise  = rise_q;
		p_fall  = fall_q;
		p_boost = boost_q;
		if (rlast_q < raw_q) begin
			p_rise = rise_q + 8'd1;
			if (p_rise >= RUN_LIMIT) p_boost = {p_rise[6:0], 1'b0};
			else if (fall_q >= RUN_LIMIT) p_boost = 8'd0;
			p_fall = 8'd0;
		end else begin
			if (rlast_q > raw_q) p_fall = fall_q + 8'd1;
			if (p_fall >= RUN_LIMIT) p_boost = {p_fall[6:0], 1'b0};
			else if (rise_q >= RUN_LIMIT) p_boost = 8'd0;
			p_rise = 8'd0;
		end

		// A long run below zero moves the zero to the current reading.
		p_bz   = bz_q;
		p_zero = zero_q;
		if (raw_q < zero_q) begin
			if (bz_q > zrc_q) begin
				if (p_boost == 8'd0) begin
					p_zero = raw_q;
					p_bz   = 8'd0;
				end
			end else begin
				p_bz = bz_q + 8'd1;
			end
		end else if (bz_q != 8'd0) begin
			p_bz = bz_q - 8'd1;
		end
	end

	always_comb begin
		hn        = hist_q[scan_q];
		m_nx      = (hn != 16'd0 && hn < m_q) ? hn : m_q;
		scan_last = (scan_q == HW'(ZERO_HISTORY - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= 7'd20;
			gain_q   <= 16'd100;
			plen_q   <= 8'd30;
			zrc_q    <= 8'd120;
			izero_q  <= 16'hFFFF;
			cnt_q    <= '0;
			sum_q    <= '0;
			low_q    <= 16'hFFFF;
			high_q   <= '0;
			pre_q    <= 8'd30;
			stable_q <= '0;
			ready_q  <= '0;
			bz_q     <= '0;
			rise_q   <= '0;
			fall_q   <= '0;
			boost_q  <= '0;
			hidx_q   <= '0;
			filt_q   <= '0;
			rlast_q  <= '0;
			zero_q   <= 16'hFFFF;
			pmin_q   <= 16'hFFFF;
			m_q      <= '0;
			mode_q   <= MODE_LOADING;
			wptr_q   <= '0;
			scan_q   <= '0;
			for (int i = 0; i < ZERO_HISTORY; i++) hist_q[i] <= '0;
			raw_q    <= '0;
			adv_q    <= '0;
			co2_q    <= '0;
			w_q      <= '0;
			lvl_q    <= '0;
			sync_q   <= 1'b0;
			out_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_WEIGHT:    fw_q   <= cfg_data[6:0];
					REG_GAIN_PERCENT:     gain_q <= cfg_data;
					REG_PREHEAT_LENGTH: begin
						plen_q <= cfg_data[7:0];
						if (mode_q == MODE_LOADING) pre_q <= cfg_data[7:0];
					end
					REG_ZERO_RESET_COUNT: zrc_q  <= cfg_data[7:0];
					REG_INITIAL_ZERO: begin
						izero_q <= cfg_data;
						if (mode_q == MODE_LOADING) zero_q <= cfg_data;
					end
					default: ;
				endcase
			end

			if (cmd.take && !item.action) begin
				if (block_end) begin
					raw_q  <= raw_n;
					cnt_q  <= '0;
					sum_q  <= '0;
					low_q  <= 16'hFFFF;
					high_q <= '0;
					sync_q <= 1'b0;
					if (pre_q != 8'd0) pre_q <= pre_q - 8'd1;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					sum_q  <= sum_n;
					low_q  <= low_n;
					high_q <= high_n;
				end
			end

			if (cmd.prep) begin
				stable_q <= p_stable;
				ready_q  <= p_ready;
				mode_q   <= p_mode;
				pmin_q   <= p_pmin;
				w_q      <= p_w;
				adv_q    <= p_adv;
				rise_q   <= p_rise;
				fall_q   <= p_fall;
				boost_q  <= p_boost;
				bz_q     <= p_bz;
				zero_q   <= p_zero;
				rlast_q  <= raw_q;
			end

			if (cmd.co2) begin
				co2_q  <= CO2_BASE + quotient[15:0];
				filt_q <= quotient[15:0];
			end

			if (cmd.grade) lvl_q <= level_of(co2_q);

			if (cmd.sync_wr) begin
				hist_q[wptr_q] <= pmin_q;
				m_q    <= pmin_q;
				scan_q <= '0;
				sync_q <= 1'b1;
			end

			if (cmd.scan) begin
				m_q    <= m_nx;
				scan_q <= scan_q + 1'b1;
				if (scan_last) begin
					zero_q <= m_nx;
					pmin_q <= 16'hFFFF;
					hidx_q <= hidx_q + 8'd1;
					// The ring position follows the 8-bit sync count modulo the depth.
					if (hidx_q == 8'hFF || wptr_q == HW'(ZERO_HISTORY - 1)) begin
						wptr_q <= '0;
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
			end

			if (cmd.load_out) begin
				out_q.mode       <= mode_q;
				out_q.zero_level <= zero_q;
				out_q.is_sync    <= sync_q;
				out_q.raw_reading <= sync_q ? 16'd0 : raw_q;
				out_q.co2_value  <= sync_q ? 16'd0 : co2_q;
				out_q.air_level  <= sync_q ? 7'd0 : lvl_q;
				out_valid_q      <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.block_end = block_end;
		stat.div_done  = div_done;
		stat.scan_last = scan_last;
		stat.out_free  = !out_valid_q || !result_stall;
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

@@ rtl/core/gas_sensor_adaptive_filter.sv @@
// ----------------------------------------------------------------------------
// gas_sensor_adaptive_filter
// Gas sensor reading filter with preheat, adaptive smoothing and zero tracking.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel (item_valid/item_stall). A transaction with
// action low adds one converter sample to the current block; when a block of
// SAMPLES_PER_BLOCK samples completes, one result transaction follows on the
// result channel (result_valid/result_stall). A transaction with action high is
// a zero sync event and always yields one result marked is_sync.
// A sample that does not complete a block leaves item_stall low. A completing
// sample walks the controller through PREP, MUL1, DIV1, MUL2, DIV2, CO2, GRADE
// and DONE, with two passes through the reciprocal divide-by-100 unit, before
// its result is presented and the next item is taken. A sync event goes through
// SYNC_WR, a one-entry-per-cycle scan of all ZERO_HISTORY entries and DONE.
// item_stall is high while a reading or sync is in progress. The result sits in
// an output register; while the receiver stalls, new samples are still taken,
// and the next finished result waits in the controller until the register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the clock
// edge and are meant for idle periods only.
// Reset clears all state, loads the register defaults, zeroes the history ring
// and starts in loading mode; the block accepts items in the first cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gas_sensor_adaptive_filter #(
	parameter int unsigned SAMPLES_PER_BLOCK = gsaf_pkg::DEF_SAMPLES_PER_BLOCK,
	parameter int unsigned ZERO_HISTORY      = gsaf_pkg::DEF_ZERO_HISTORY
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gsaf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsaf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  gsaf_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output gsaf_pkg::result_t              result
);
	import gsaf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The controller sequences each transaction through the datapath.
	gsaf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_action (item.action),
		.stat        (stat),
		.cmd         (cmd),
		.item_stall  (item_stall)
	);

	// The datapath holds all filter state and the output register.
	gsaf_dp #(
		.SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
		.ZERO_HISTORY      (ZERO_HISTORY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	// An accepted sync transaction must go straight to the history write.
	`GSAF_ASSERT(a_sync_starts, (item_valid && !item_stall && item.action) |=> cmd.sync_wr, "sync transaction did not start history write")

	// A result is only loaded when the output register can take it.
	`GSAF_NEVER(a_no_overwrite, cmd.load_out && result_valid && result_stall, "result register overwritten while stalled")

	// The filtered value is only taken once the divider has finished.
	`GSAF_ASSERT(a_div_finished, cmd.co2 |-> stat.div_done, "co2 taken before division finished")

endmodule

@@ bench/gsaf_checker.sv @@
// ----------------------------------------------------------------------------
// gsaf_checker
// Watches both channels of the gas sensor filter, predicts each reading and
// sync answer from its own model of the block, and compares them in order.
// ----------------------------------------------------------------------------
module gsaf_checker
	import gsaf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPB = DEF_SAMPLES_PER_BLOCK;
	localparam int ZH  = DEF_ZERO_HISTORY;

	logic [6:0]  k_weight;
	logic [15:0] k_gain, k_zinit;
	logic [7:0]  k_preheat, k_zreset;

	logic [7:0]  blk_cnt, pre_cnt, stable_t, ready_t, below_cnt, rise_n, fall_n, boost, hist_idx;
	logic [15:0] blk_sum, blk_lo, blk_hi, filt_prev, raw_prev, zero_off, per_min;
	logic [1:0]  mode_q;
	logic [15:0] zhist [ZH];

	result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic logic [6:0] grade_of(input int unsigned v);
		if (v < 400) return 100;
		if (v < 1000) return 7'(100 - (v - 400) / 30);
		if (v < 1800) return 7'(80 - (v - 1000) / 40);
		if (v < 5000) return 7'(60 - 3 * (v - 1800) / 160);
		return 0;
	endfunction

	task automatic model_reset();
		k_weight = 20; k_gain = 100; k_preheat = 30; k_zreset = 120; k_zinit = 16'hFFFF;
		blk_cnt = 0; blk_sum = 0; blk_lo = 16'hFFFF; blk_hi = 0;
		pre_cnt = k_preheat; stable_t = 0; ready_t = 0; below_cnt = 0;
		rise_n = 0; fall_n = 0; boost = 0; filt_prev = 0; raw_prev = 0;
		zero_off = k_zinit; per_min = 16'hFFFF; mode_q = MODE_LOADING; hist_idx = 0;
		foreach (zhist[i]) zhist[i] = 0;
	endtask

	task automatic model_write(input logic [2:0] idx, input logic [15:0] d);
		case (idx)
			REG_FILTER_WEIGHT: k_weight = d[6:0];
			REG_GAIN_PERCENT: k_gain = d;
			REG_PREHEAT_LENGTH: begin
				k_preheat = d[7:0];
				if (mode_q == MODE_LOADING) pre_cnt = k_preheat;
			end
			REG_ZERO_RESET_COUNT: k_zreset = d[7:0];
			REG_INITIAL_ZERO: begin
				k_zinit = d;
				if (mode_q == MODE_LOADING) zero_off = k_zinit;
			end
			default: ;
		endcase
	endtask

	// One finished block reading through preheat, filter and zero tracking.
	function automatic result_t run_reading(input logic [15:0] raw);
		result_t r;
		logic [15:0] zero;
		int unsigned w, adv, sens;
		longint unsigned prod;
		logic [15:0] co2;
		zero = zero_off;
		w = k_weight;
		if (pre_cnt == 0) begin
			w = (w + boost) & 8'hFF;
			if (stable_t > 0) begin
				stable_t = stable_t - 1;
				if (boost > 0) ready_t = 0;
				else begin
					ready_t = ready_t + 1;
					if (ready_t >= READY_LIMIT && stable_t > 10) begin
						stable_t = stable_t - 10;
						ready_t = 0;
					end
				end
			end else begin
				mode_q = MODE_NORMAL;
				if (per_min > raw && raw >= zero) per_min = raw;
			end
		end else if (pre_cnt < QUIET_LIMIT) begin
			stable_t = k_preheat;
			ready_t = 0;
		end else mode_q = MODE_PREHEAT;
		if (w > 100) w = 100;
		adv = (raw > zero) ? raw - zero : 0;
		prod = longint'(adv) * k_gain / 100;
		adv = prod & 16'hFFFF;
		sens = (adv * w + (100 - w) * filt_prev) / 100;
		if (raw_prev < raw) begin
			rise_n = rise_n + 1;
			if (rise_n >= RUN_LIMIT) boost = rise_n << 1;
			else if (fall_n >= RUN_LIMIT) boost = 0;
			fall_n = 0;
		end else begin
			if (raw_prev > raw) fall_n = fall_n + 1;
			if (fall_n >= RUN_LIMIT) boost = fall_n << 1;
			else if (rise_n >= RUN_LIMIT) boost = 0;
			rise_n = 0;
		end
		if (raw < zero) begin
			if (below_cnt > k_zreset) begin
				if (boost == 0) begin
					zero_off = raw;
					below_cnt = 0;
				end
			end else below_cnt = below_cnt + 1;
		end else if (below_cnt > 0) below_cnt = below_cnt - 1;
		co2 = 16'(400 + sens);
		filt_prev = 16'(sens);
		raw_prev = raw;
		r.raw_reading = raw; r.co2_value = co2; r.air_level = grade_of(co2);
		r.mode = mode_q; r.zero_level = zero_off; r.is_sync = 1'b0;
		return r;
	endfunction

	task automatic model_item(input item_t it);
		result_t r;
		logic [15:0] m, raw;
		if (it.action) begin
			m = per_min;
			zhist[hist_idx % ZH] = m;
			foreach (zhist[i]) if (zhist[i] != 0 && zhist[i] < m) m = zhist[i];
			hist_idx = hist_idx + 1;
			zero_off = m;
			per_min = 16'hFFFF;
			r = '0;
			r.mode = mode_q; r.zero_level = zero_off; r.is_sync = 1'b1;
			expected_q.push_back(r);
		end else begin
			blk_sum = blk_sum + it.sample;
			if (it.sample < blk_lo) blk_lo = it.sample;
			if (it.sample > blk_hi) blk_hi = it.sample;
			if (blk_cnt >= SPB - 1) begin
				raw = blk_sum - blk_lo - blk_hi;
				blk_cnt = 0; blk_sum = 0; blk_lo = 16'hFFFF; blk_hi = 0;
				if (pre_cnt > 0) pre_cnt = pre_cnt - 1;
				expected_q.push_back(run_reading(raw));
			end else blk_cnt = blk_cnt + 1;
		end
	endtask

	task automatic compare(input string name, input int unsigned e, input int unsigned a);
		if (e != a) begin
			$error("%s: expected %0d, actual %0d", name, e, a);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		model_reset();
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					compare("raw_reading", e.raw_reading, result.raw_reading);
					compare("co2_value", e.co2_value, result.co2_value);
					compare("air_level", e.air_level, result.air_level);
					compare("mode", e.mode, result.mode);
					compare("zero_level", e.zero_level, result.zero_level);
					compare("is_sync", e.is_sync, result.is_sync);
				end
			end
			if (cfg_we) model_write(cfg_index, cfg_data);
			if (item_valid && !item_stall) model_item(item);
		end
	end
endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gas sensor adaptive filter: register settings,
// directed corner readings, random blocks and sync events under idling and stalling.
// ----------------------------------------------------------------------------
module tb_top;
	import gsaf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        item_valid, item_stall, result_valid, result_stall;
	item_t       item;
	result_t     result;
	int          fail_count, pending;

	// Percent chance per cycle that the sender idles and the receiver stalls.
	int unsigned idle_pct, stall_pct;
	int unsigned quiet_cycles;

	gas_sensor_adaptive_filter u_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result
	);

	gsaf_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random with the current phase's rate.
	always @(posedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	// Watchdog: a long stretch with no transaction on either side means a hang.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Send one transaction, idling first at the phase's rate. Valid stays high
	// across back-to-back transactions so it is never pulsed within one step.
	// The stall is sampled at the falling edge, where it is settled for the
	// next rising edge.
	task automatic send_item(input logic act, input logic [15:0] s);
		logic stalled;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{action: act, sample: s};
		do begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	// Bring the block to rest, then let the longest reading time pass so that
	// a non-completing sample cannot still be in flight.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(input logic [15:0] base, input int unsigned spread);
		for (int i = 0; i < DEF_SAMPLES_PER_BLOCK; i++)
			send_item(1'b0, 16'(base + $urandom_range(spread)));
	endtask

	initial begin
		int unsigned phase;
		logic [15:0] level;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		item_valid = 0; item = '0; result_stall = 0;
		idle_pct = 0; stall_pct = 0; quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Short preheat so that normal mode and zero tracking are reached.
		write_reg(REG_PREHEAT_LENGTH, 16'd12);
		write_reg(REG_INITIAL_ZERO, 16'd1000);
		write_reg(REG_ZERO_RESET_COUNT, 16'd3);

		// Directed: sample extremes, a sync while loading, and a wrapping sum.
		send_item(1'b1, 16'h0000);
		for (int i = 0; i < 8; i++) send_item(1'b0, 16'hFFFF);
		for (int i = 0; i < 8; i++) send_item(1'b0, (i % 2) ? 16'hFFFF : 16'h0000);
		send_item(1'b1, 16'hFFFF);
		drain();

		// Register extremes: weight and gain at their top and at zero, one block each.
		write_reg(REG_FILTER_WEIGHT, 16'd127);
		write_reg(REG_GAIN_PERCENT, 16'hFFFF);
		send_block(16'h8000, 16'h7FFF);
		drain();
		write_reg(REG_FILTER_WEIGHT, 16'd0);
		write_reg(REG_GAIN_PERCENT, 16'd0);
		send_block(16'd0, 16'hFFFF);
		drain();

		// Random phases: rising and falling ramps drive the weight boost, low
		// stretches exercise re-baselining, and syncs refresh the zero history.
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 62; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 62; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			write_reg(REG_FILTER_WEIGHT, 16'($urandom_range(127)));
			write_reg(REG_GAIN_PERCENT,
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300)));
			write_reg(REG_ZERO_RESET_COUNT,
				(phase == 7) ? 16'd255 : 16'($urandom_range(10)));
			write_reg(REG_PREHEAT_LENGTH, (phase == 5) ? 16'd255 : 16'($urandom_range(20)));
			write_reg(REG_INITIAL_ZERO, (phase == 6) ? 16'd0 : 16'($urandom));
			level = 16'($urandom_range(4000));
			for (int b = 0; b < 14; b++) begin
				case ($urandom_range(5))
					0: level = level + 16'($urandom_range(200));
					1: level = level - 16'($urandom_range(200));
					2: level = 16'($urandom);
					default: ;
				endcase
				if ($urandom_range(9) == 0) send_item(1'b1, 16'($urandom));
				send_block(level, $urandom_range(1) ? 16'd40 : 16'hFFFF);
			end
			drain();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
